### design/chmr_pkg.sv
// Shared types, widths and default parameter values for the column height map.
package chmr_pkg;

  localparam int unsigned MAX_INDEX_DEF  = 16383;
  localparam int unsigned SLOT_SHIFT_DEF = 7;

  localparam int unsigned OP_W     = 2;
  localparam int unsigned COORD_W  = 24;
  localparam int unsigned DIM_W    = 16;
  localparam int unsigned HEIGHT_W = 24;

  localparam logic [HEIGHT_W-1:0] HEIGHT_MAX = '1;

  typedef enum logic [OP_W-1:0] {
    OP_ADD   = 2'd0,
    OP_QUERY = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREV_RD,
    ST_PREV_LATCH,
    ST_FILL,
    ST_RAW_RD,
    ST_RAW_UPD,
    ST_Q_RUN,
    ST_Q_DRAIN,
    ST_FINISH
  } state_e;

endpackage

### design/chmr_in_if.sv
// Input channel of the column height map: one command beat.
interface chmr_in_if;
  import chmr_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [OP_W-1:0]            op;
  logic signed [COORD_W-1:0]  brick_left;
  logic signed [COORD_W-1:0]  brick_top;
  logic [DIM_W-1:0]           brick_width;
  logic [DIM_W-1:0]           brick_height;
  logic signed [COORD_W-1:0]  query_left;
  logic signed [COORD_W-1:0]  query_right;

  modport source (
    output valid, op, brick_left, brick_top, brick_width, brick_height,
           query_left, query_right,
    input  ready
  );

  modport sink (
    input  valid, op, brick_left, brick_top, brick_width, brick_height,
           query_left, query_right,
    output ready
  );

endinterface

### design/chmr_out_if.sv
// Output channel of the column height map: one result beat.
interface chmr_out_if;
  import chmr_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [HEIGHT_W-1:0]  peak_height;
  logic                 world_empty;
  logic [HEIGHT_W-1:0]  extent_x_out;
  logic [HEIGHT_W-1:0]  extent_y_out;

  modport source (
    output valid, peak_height, world_empty, extent_x_out, extent_y_out,
    input  ready
  );

  modport sink (
    input  valid, peak_height, world_empty, extent_x_out, extent_y_out,
    output ready
  );

endinterface

### design/column_height_map_range_max.sv
// Column height map with range-maximum query, built around two column memories.
//
// The block keeps one raw and one smoothed height per column of 2^SLOT_SHIFT
// pixels in two single-port-write, single-port-read memories of MAX_INDEX+1
// entries each, and handles one command beat at a time. A clear, an unused
// opcode, a query on an empty world and a query with a reversed range go
// straight to the finish step. A query that walks columns l..r reads them in
// turn, because the smoothed memory delivers one entry per cycle, and then
// drains the last read before it finishes. An add whose column is already in
// use reads the raw entry, updates it and finishes; an add that extends the
// map to column c first reads the last used entry and then writes each new
// column once before that read and update. The finish step waits while the
// previous result is still held in the output register. Every command
// produces exactly one result beat; a new command is taken as soon as the
// sequencer is idle, even while the previous result still waits in the output
// register. No clearing pass is needed after reset: columns beyond the used
// length are written before they are ever read, and column zero reads as zero
// until it is first written.
module column_height_map_range_max_core #(
  parameter int unsigned MAX_INDEX  = chmr_pkg::MAX_INDEX_DEF,
  parameter int unsigned SLOT_SHIFT = chmr_pkg::SLOT_SHIFT_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  chmr_in_if.sink    in_i,
  chmr_out_if.source out_o
);
  import chmr_pkg::*;

  localparam int unsigned COLS = MAX_INDEX + 1;
  localparam int unsigned IW   = $clog2(COLS);
  localparam int unsigned UW   = $clog2(COLS + 1);
  localparam int unsigned XW   = COORD_W + 1;

  // Maps a pixel x to its column: negative goes to zero, far ones saturate.
  function automatic logic [IW-1:0] column_of(logic signed [XW-1:0] x);
    logic signed [XW-1:0] c;
    c = x >>> SLOT_SHIFT;
    if (x < 0) begin
      return '0;
    end else if (c > $signed(XW'(MAX_INDEX))) begin
      return IW'(MAX_INDEX);
    end
    return IW'(c);
  endfunction

  // Raises an extent to a new edge, saturating at the field maximum.
  function automatic logic [HEIGHT_W-1:0] raise_ext(logic [HEIGHT_W-1:0]  ext,
                                                    logic signed [XW-1:0] e);
    if (e > $signed({1'b0, ext})) begin
      if (e > $signed({1'b0, HEIGHT_MAX})) begin
        return HEIGHT_MAX;
      end
      return e[HEIGHT_W-1:0];
    end
    return ext;
  endfunction

  // Column memories.
  logic [HEIGHT_W-1:0] raw_mem [COLS];
  logic [HEIGHT_W-1:0] sm_mem  [COLS];

  state_e              state_q, state_d;
  logic [UW-1:0]       used_q, used_d;
  logic [HEIGHT_W-1:0] ext_r_q, ext_r_d;
  logic [HEIGHT_W-1:0] ext_b_q, ext_b_d;
  logic [HEIGHT_W-1:0] cnt_q, cnt_d;
  logic [IW-1:0]       idx_q, idx_d;
  logic signed [XW-1:0] bottom_q, bottom_d;
  logic [IW-1:0]       j_q, j_d;
  logic [HEIGHT_W-1:0] prev_q, prev_d;
  logic [IW-1:0]       qi_q, qi_d;
  logic [IW-1:0]       qr_q, qr_d;
  logic [HEIGHT_W-1:0] best_q, best_d;
  logic                sm_rv_q;
  logic                raw_e0_q, raw_e0_d;
  logic                sm_e0_q, sm_e0_d;
  logic                raw_z_q, sm_z_q;
  logic [HEIGHT_W-1:0] raw_rd_q, sm_rd_q;

  logic                out_valid_q, out_valid_d;
  logic [HEIGHT_W-1:0] out_mh_q, out_mh_d;
  logic                out_empty_q, out_empty_d;
  logic [HEIGHT_W-1:0] out_w_q, out_w_d;
  logic [HEIGHT_W-1:0] out_h_q, out_h_d;

  // Memory port controls.
  logic                raw_we, sm_we, raw_re, sm_re;
  logic [IW-1:0]       wr_addr, raw_ra, sm_ra;
  logic [HEIGHT_W-1:0] raw_wdata, sm_wdata;

  // Read data with the never-written column zero forced to zero.
  logic [HEIGHT_W-1:0] raw_data, sm_data;
  assign raw_data = raw_z_q ? '0 : raw_rd_q;
  assign sm_data  = sm_z_q  ? '0 : sm_rd_q;

  // Decode of the incoming beat.
  logic                 in_fire;
  logic signed [XW-1:0] center, right_edge, bottom_edge, ql, qr;
  logic [IW-1:0]        col_c, col_l, col_r, last_col;
  logic [HEIGHT_W-1:0]  raw_new;

  assign in_i.ready  = (state_q == ST_IDLE);
  assign in_fire     = in_i.valid && in_i.ready;
  assign center      = XW'(in_i.brick_left)
                     + $signed({{(XW-DIM_W+1){1'b0}}, in_i.brick_width[DIM_W-1:1]});
  assign right_edge  = XW'(in_i.brick_left) + $signed({{(XW-DIM_W){1'b0}}, in_i.brick_width});
  assign bottom_edge = XW'(in_i.brick_top) + $signed({{(XW-DIM_W){1'b0}}, in_i.brick_height});
  assign ql          = XW'(in_i.query_left);
  assign qr          = XW'(in_i.query_right);
  assign last_col    = IW'(used_q - UW'(1));
  assign col_c       = column_of(center);
  assign col_l       = (column_of(ql) > last_col) ? last_col : column_of(ql);
  assign col_r       = (column_of(qr) > last_col) ? last_col : column_of(qr);

  // A bottom above the stored maximum raises it, saturating.
  always_comb begin
    raw_new = raw_data;
    if (bottom_q > $signed({1'b0, raw_data})) begin
      raw_new = (bottom_q > $signed({1'b0, HEIGHT_MAX})) ? HEIGHT_MAX
                                                          : bottom_q[HEIGHT_W-1:0];
    end
  end

  always_comb begin
    state_d     = state_q;
    used_d      = used_q;
    ext_r_d     = ext_r_q;
    ext_b_d     = ext_b_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    bottom_d    = bottom_q;
    j_d         = j_q;
    prev_d      = prev_q;
    qi_d        = qi_q;
    qr_d        = qr_q;
    best_d      = best_q;
    raw_e0_d    = raw_e0_q;
    sm_e0_d     = sm_e0_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_mh_d    = out_mh_q;
    out_empty_d = out_empty_q;
    out_w_d     = out_w_q;
    out_h_d     = out_h_q;
    raw_we      = 1'b0;
    sm_we       = 1'b0;
    raw_re      = 1'b0;
    sm_re       = 1'b0;
    wr_addr     = j_q;
    raw_ra      = idx_q;
    sm_ra       = qi_q;
    raw_wdata   = '0;
    sm_wdata    = prev_q;

    // Query reads come back in the cycle after they are issued.
    if (sm_rv_q && (sm_data > best_q)) begin
      best_d = sm_data;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          best_d = '0;
          unique case (op_e'(in_i.op))
            OP_ADD: begin
              if (cnt_q != HEIGHT_MAX) begin
                cnt_d = cnt_q + HEIGHT_W'(1);
              end
              ext_r_d  = raise_ext(ext_r_q, right_edge);
              ext_b_d  = raise_ext(ext_b_q, bottom_edge);
              idx_d    = col_c;
              bottom_d = bottom_edge;
              state_d  = (UW'(col_c) >= used_q) ? ST_PREV_RD : ST_RAW_RD;
            end
            OP_QUERY: begin
              qi_d = col_l;
              qr_d = col_r;
              if ((cnt_q == '0) || (qr < ql)) begin
                state_d = ST_FINISH;
              end else begin
                state_d = ST_Q_RUN;
              end
            end
            OP_CLEAR: begin
              used_d   = UW'(1);
              ext_r_d  = HEIGHT_W'(1);
              ext_b_d  = HEIGHT_W'(1);
              cnt_d    = '0;
              raw_e0_d = 1'b0;
              sm_e0_d  = 1'b0;
              state_d  = ST_FINISH;
            end
            OP_NONE: begin
              state_d = ST_FINISH;
            end
          endcase
        end
      end
      ST_PREV_RD: begin
        sm_re   = 1'b1;
        sm_ra   = last_col;
        state_d = ST_PREV_LATCH;
      end
      ST_PREV_LATCH: begin
        prev_d  = sm_data;
        j_d     = IW'(used_q);
        state_d = ST_FILL;
      end
      ST_FILL: begin
        raw_we = 1'b1;
        sm_we  = 1'b1;
        if (j_q == idx_q) begin
          used_d  = UW'(idx_q) + UW'(1);
          state_d = ST_RAW_RD;
        end else begin
          j_d = j_q + IW'(1);
        end
      end
      ST_RAW_RD: begin
        raw_re  = 1'b1;
        state_d = ST_RAW_UPD;
      end
      ST_RAW_UPD: begin
        wr_addr   = idx_q;
        raw_we    = 1'b1;
        raw_wdata = raw_new;
        sm_wdata  = raw_new;
        sm_we     = (raw_new != '0);
        if (idx_q == '0) begin
          raw_e0_d = 1'b1;
          if (raw_new != '0) begin
            sm_e0_d = 1'b1;
          end
        end
        state_d = ST_FINISH;
      end
      ST_Q_RUN: begin
        sm_re = 1'b1;
        if (qi_q == qr_q) begin
          state_d = ST_Q_DRAIN;
        end else begin
          qi_d = qi_q + IW'(1);
        end
      end
      ST_Q_DRAIN: begin
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_mh_d    = best_q;
          out_empty_d = (cnt_q == '0);
          out_w_d     = ext_r_q;
          out_h_d     = ext_b_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      used_q      <= UW'(1);
      ext_r_q     <= HEIGHT_W'(1);
      ext_b_q     <= HEIGHT_W'(1);
      cnt_q       <= '0;
      sm_rv_q     <= 1'b0;
      raw_e0_q    <= 1'b0;
      sm_e0_q     <= 1'b0;
      raw_z_q     <= 1'b0;
      sm_z_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      ext_r_q     <= ext_r_d;
      ext_b_q     <= ext_b_d;
      cnt_q       <= cnt_d;
      sm_rv_q     <= (state_q == ST_Q_RUN);
      raw_e0_q    <= raw_e0_d;
      sm_e0_q     <= sm_e0_d;
      out_valid_q <= out_valid_d;
      if (raw_re) begin
        raw_z_q <= (raw_ra == '0) && !raw_e0_q;
      end
      if (sm_re) begin
        sm_z_q <= (sm_ra == '0) && !sm_e0_q;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    idx_q       <= idx_d;
    bottom_q    <= bottom_d;
    j_q         <= j_d;
    prev_q      <= prev_d;
    qi_q        <= qi_d;
    qr_q        <= qr_d;
    best_q      <= best_d;
    out_mh_q    <= out_mh_d;
    out_empty_q <= out_empty_d;
    out_w_q     <= out_w_d;
    out_h_q     <= out_h_d;
  end

  // Memory ports: one write and one registered read per memory.
  always_ff @(posedge clk_i) begin
    if (raw_we) begin
      raw_mem[wr_addr] <= raw_wdata;
    end
    if (sm_we) begin
      sm_mem[wr_addr] <= sm_wdata;
    end
    if (raw_re) begin
      raw_rd_q <= raw_mem[raw_ra];
    end
    if (sm_re) begin
      sm_rd_q <= sm_mem[sm_ra];
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.peak_height  = out_mh_q;
  assign out_o.world_empty  = out_empty_q;
  assign out_o.extent_x_out = out_w_q;
  assign out_o.extent_y_out = out_h_q;

  a_used_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (used_q != '0) && (used_q <= UW'(COLS)))
    else $error("used column count out of range");

  a_fill_beyond_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FILL) |-> ((UW'(j_q) >= used_q) && (j_q <= idx_q)))
    else $error("forward fill writes inside the used columns");

  a_query_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_Q_RUN) |-> ((qi_q <= qr_q) && (UW'(qr_q) < used_q)))
    else $error("query walk outside the used columns");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.world_empty) |-> (out_o.peak_height == '0))
    else $error("nonzero height reported for an empty world");

endmodule

### verif/tb_column_height_map_range_max_core.sv
// Self-checking testbench for the column height map core: random and directed command beats.
`timescale 1ns / 1ps

module tb_column_height_map_range_max_core;
  import chmr_pkg::*;

  localparam int unsigned MAX_COL = MAX_INDEX_DEF;
  localparam int unsigned SHIFT   = SLOT_SHIFT_DEF;

  // Coordinate extremes of the 24-bit signed fields.
  localparam logic signed [COORD_W-1:0] C_MIN = {1'b1, {(COORD_W-1){1'b0}}};
  localparam logic signed [COORD_W-1:0] C_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic [DIM_W-1:0]          D_MAX = '1;

  // Column distance above which an add or a query counts as slow for the block.
  localparam int unsigned SLOW_SPAN = 1024;
  localparam int unsigned N_RANDOM  = 1330;

  // One command beat plus the idle cycles before it and an optional drain request.
  typedef struct {
    op_e                       op;
    logic signed [COORD_W-1:0] brick_left;
    logic signed [COORD_W-1:0] brick_top;
    logic [DIM_W-1:0]          brick_width;
    logic [DIM_W-1:0]          brick_height;
    logic signed [COORD_W-1:0] query_left;
    logic signed [COORD_W-1:0] query_right;
    int unsigned               gap;
    bit                        drain;
  } map_cmd_t;

  // One result beat.
  typedef struct {
    logic [HEIGHT_W-1:0] peak_height;
    logic                world_empty;
    logic [HEIGHT_W-1:0] extent_x;
    logic [HEIGHT_W-1:0] extent_y;
  } map_status_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  chmr_in_if  cmd_ch ();
  chmr_out_if status_ch ();

  column_height_map_range_max_core #(
    .MAX_INDEX  (MAX_COL),
    .SLOT_SHIFT (SHIFT)
  ) DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (cmd_ch),
    .out_o  (status_ch)
  );

  always #10 clk_i = ~clk_i;

  // Reset is released at a falling edge so that it never races the sampling edge.
  initial begin
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  // ---------------------------------------------------------------------------
  // Predicted state of the height map. It is updated in the order in which
  // command beats are accepted, which is also the order of the result beats.
  // ---------------------------------------------------------------------------
  logic [HEIGHT_W-1:0] raw_hgt    [0:MAX_COL];
  logic [HEIGHT_W-1:0] smooth_hgt [0:MAX_COL];
  int unsigned         used_cols;
  longint              ext_right;
  longint              ext_bottom;
  int unsigned         rect_cnt;

  map_cmd_t    cmd_backlog[$];
  map_status_t status_due_q[$];

  // Handshake flags, sampled at the rising edge and consumed at the falling edge.
  bit cmd_taken = 1'b0;
  bit res_taken = 1'b0;
  bit sink_hold = 1'b0;

  int unsigned results_seen = 0;
  int unsigned cmds_taken   = 0;
  int unsigned total_cmds   = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned n_adds = 0, n_queries = 0, n_hits = 0, n_clears = 0, n_unused = 0;

  function automatic void wipe_map();
    foreach (raw_hgt[i]) begin
      raw_hgt[i]    = '0;
      smooth_hgt[i] = '0;
    end
    used_cols  = 1;
    ext_right  = 1;
    ext_bottom = 1;
    rect_cnt   = 0;
  endfunction

  // Pixel x to column, with negative positions on column 0 and far ones on the last.
  function automatic int unsigned col_of(longint x);
    longint c;
    if (x < 0) return 0;
    c = x >>> SHIFT;
    return (c > longint'(MAX_COL)) ? MAX_COL : int'(c);
  endfunction

  // Extents only grow, and they saturate at the top of the 24-bit range.
  function automatic longint grown_extent(longint ext, longint reach);
    if (reach > longint'(HEIGHT_MAX)) reach = longint'(HEIGHT_MAX);
    return (reach > ext) ? reach : ext;
  endfunction

  function automatic map_status_t apply_to_height_map(map_cmd_t c);
    map_status_t         s;
    longint              left, w, h, bottom;
    int unsigned         col, lo, hi, j;
    logic [HEIGHT_W-1:0] best;
    best = '0;
    case (c.op)
      OP_ADD: begin
        left   = c.brick_left;
        w      = longint'(c.brick_width);
        h      = longint'(c.brick_height);
        bottom = longint'(c.brick_top) + h;
        if (rect_cnt < HEIGHT_MAX) rect_cnt++;
        ext_right  = grown_extent(ext_right, left + w);
        ext_bottom = grown_extent(ext_bottom, bottom);
        // The center column, then forward fill of every newly used column.
        col = col_of(left + (w >>> 1));
        for (j = used_cols; j <= col; j++) begin
          raw_hgt[j]    = '0;
          smooth_hgt[j] = smooth_hgt[j-1];
        end
        if (col + 1 > used_cols) used_cols = col + 1;
        if (bottom > longint'(raw_hgt[col]))
          raw_hgt[col] = (bottom > longint'(HEIGHT_MAX)) ? HEIGHT_MAX : bottom[HEIGHT_W-1:0];
        if (raw_hgt[col] != '0) smooth_hgt[col] = raw_hgt[col];
      end
      OP_QUERY: begin
        // An empty world or a reversed range reports height zero.
        if (rect_cnt != 0 && c.query_right >= c.query_left) begin
          lo = col_of(c.query_left);
          hi = col_of(c.query_right);
          if (lo > used_cols - 1) lo = used_cols - 1;
          if (hi > used_cols - 1) hi = used_cols - 1;
          for (j = lo; j <= hi; j++)
            if (smooth_hgt[j] > best) best = smooth_hgt[j];
        end
      end
      OP_CLEAR: wipe_map();
      default: ;
    endcase
    s.peak_height = best;
    s.world_empty = (rect_cnt == 0);
    s.extent_x    = ext_right[HEIGHT_W-1:0];
    s.extent_y    = ext_bottom[HEIGHT_W-1:0];
    return s;
  endfunction

  function automatic map_cmd_t mk_cmd(op_e op,
                                      logic signed [COORD_W-1:0] bl, logic signed [COORD_W-1:0] bt,
                                      logic [DIM_W-1:0] bw, logic [DIM_W-1:0] bh,
                                      logic signed [COORD_W-1:0] ql,
                                      logic signed [COORD_W-1:0] qr);
    map_cmd_t c;
    c.op           = op;
    c.brick_left   = bl;
    c.brick_top    = bt;
    c.brick_width  = bw;
    c.brick_height = bh;
    c.query_left   = ql;
    c.query_right  = qr;
    c.gap          = 0;
    c.drain        = 1'b0;
    return c;
  endfunction

  // Mode 0 never idles, mode 1 draws a random idle gap for every beat, mode 2 idles only now and then.
  function automatic int unsigned draw_idle(int unsigned mode);
    case (mode)
      0:       return 0;
      1:       return $urandom_range(0, 18);
      default: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 18) : 0;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus. A short directed list walks the corner cases, then random beats
  // follow. Most random beats stay within a few hundred columns so that the
  // block stays fast; full-range noise supplies the extreme bit patterns, and
  // the number of noise beats that would make the block walk most of the map
  // is capped.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    map_cmd_t              c;
    int unsigned           tx_mode, pick, n;
    int                    far_left, wide_left;
    longint                l, t;
    logic [DIM_W-1:0]      w, h;
    logic signed [COORD_W-1:0] swap;

    wipe_map();

    // A query and an unused opcode on the empty world after reset.
    cmd_backlog.push_back(mk_cmd(OP_QUERY, 0, 0, 0, 0, C_MIN, C_MAX));
    cmd_backlog.push_back(mk_cmd(OP_NONE, 0, 0, 0, 0, 0, 0));
    // A zero-size rectangle at the origin: its bottom of zero leaves the column at zero.
    cmd_backlog.push_back(mk_cmd(OP_ADD, 0, 0, 0, 0, 0, 0));
    cmd_backlog.push_back(mk_cmd(OP_QUERY, 0, 0, 0, 0, 0, 0));
    // Negative center and negative bottom land on column 0 and change nothing there.
    cmd_backlog.push_back(mk_cmd(OP_ADD, C_MIN, C_MIN, D_MAX, D_MAX, 0, 0));
    // Grows the map to column 3, filling columns 1 and 2 from column 0.
    cmd_backlog.push_back(mk_cmd(OP_ADD, 300, 100, 200, 50, 0, 0));
    cmd_backlog.push_back(mk_cmd(OP_ADD, 0, -50, 10, 20, 0, 0));
    cmd_backlog.push_back(mk_cmd(OP_QUERY, 0, 0, 0, 0, -1000, 500));
    // Far corner: the column saturates at the last index and both extents grow to the largest edge the fields can give.
    cmd_backlog.push_back(mk_cmd(OP_ADD, C_MAX, C_MAX, D_MAX, D_MAX, 0, 0));
    cmd_backlog.push_back(mk_cmd(OP_QUERY, 0, 0, 0, 0, C_MIN, C_MAX));
    cmd_backlog.push_back(mk_cmd(OP_QUERY, 0, 0, 0, 0, 1000, 999));
    cmd_backlog.push_back(mk_cmd(OP_QUERY, 0, 0, 0, 0, C_MAX, C_MAX));
    cmd_backlog.push_back(mk_cmd(OP_NONE, C_MAX, C_MAX, D_MAX, D_MAX, C_MAX, C_MAX));
    // Clear, then check that new columns fill from zero again.
    cmd_backlog.push_back(mk_cmd(OP_CLEAR, 0, 0, 0, 0, 0, 0));
    cmd_backlog.push_back(mk_cmd(OP_QUERY, 0, 0, 0, 0, 0, 1000));
    cmd_backlog.push_back(mk_cmd(OP_ADD, 640, 0, 255, 300, 0, 0));
    cmd_backlog.push_back(mk_cmd(OP_ADD, 700, 0, 1, 10, 0, 0));
    cmd_backlog.push_back(mk_cmd(OP_QUERY, 0, 0, 0, 0, 0, 1000));
    cmd_backlog.push_back(mk_cmd(OP_CLEAR, 0, 0, 0, 0, 0, 0));
    cmd_backlog.push_back(mk_cmd(OP_ADD, -5, 2000, 0, 0, 0, 0));

    far_left  = 12;
    wide_left = 24;
    for (n = 0; n < N_RANDOM; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 48) begin
        l = longint'($urandom_range(0, 8800)) - 300;
        t = longint'($urandom_range(0, 6000)) - 1000;
        w = ($urandom_range(0, 4) == 0) ? DIM_W'($urandom) : DIM_W'($urandom_range(0, 1023));
        h = ($urandom_range(0, 4) == 0) ? DIM_W'($urandom) : DIM_W'($urandom_range(0, 4095));
        c = mk_cmd(OP_ADD, COORD_W'(l), COORD_W'(t), w, h,
                   COORD_W'($urandom), COORD_W'($urandom));
      end else if (pick < 83) begin
        l = longint'($urandom_range(0, 12000)) - 1000;
        t = l + longint'($urandom_range(0, 6000)) - 200;
        c = mk_cmd(OP_QUERY, COORD_W'($urandom), COORD_W'($urandom), DIM_W'($urandom),
                   DIM_W'($urandom), COORD_W'(l), COORD_W'(t));
      end else if (pick < 86) begin
        c = mk_cmd(OP_CLEAR, 0, 0, 0, 0, 0, 0);
      end else if (pick < 88) begin
        c = mk_cmd(OP_NONE, COORD_W'($urandom), COORD_W'($urandom), DIM_W'($urandom),
                   DIM_W'($urandom), COORD_W'($urandom), COORD_W'($urandom));
      end else begin
        c = mk_cmd(op_e'($urandom_range(0, 3)), COORD_W'($urandom), COORD_W'($urandom),
                   DIM_W'($urandom), DIM_W'($urandom), COORD_W'($urandom),
                   COORD_W'($urandom));
        // Keep the slow cases rare: a far add makes the block fill thousands of
        // columns, and a wide query walks them all.
        if (c.op == OP_ADD &&
            col_of(longint'(c.brick_left) + (longint'(c.brick_width) >>> 1)) > SLOW_SPAN) begin
          if (far_left == 0) c.brick_left[COORD_W-1] = 1'b1;
          else far_left--;
        end
        if (c.op == OP_QUERY && c.query_right >= c.query_left &&
            col_of(c.query_right) - col_of(c.query_left) > SLOW_SPAN) begin
          if (wide_left == 0) begin
            swap          = c.query_left;
            c.query_left  = c.query_right;
            c.query_right = swap;
          end else begin
            wide_left--;
          end
        end
      end
      cmd_backlog.push_back(c);
    end

    // Sender idling changes character every hundred beats; a few beats wait
    // until every outstanding result has come back.
    tx_mode = 0;
    foreach (cmd_backlog[i]) begin
      if (i % 100 == 0) tx_mode = $urandom_range(0, 2);
      cmd_backlog[i].gap = draw_idle(tx_mode);
    end
    cmd_backlog[170].drain  = 1'b1;
    cmd_backlog[620].drain  = 1'b1;
    cmd_backlog[1020].drain = 1'b1;
    total_cmds = cmd_backlog.size();
  end

  // ---------------------------------------------------------------------------
  // Driver: presents one command beat at a time at the falling edge and holds
  // it until the block takes it.
  // ---------------------------------------------------------------------------
  map_cmd_t    cur;
  bit          have_cur = 1'b0;
  int unsigned cur_wait = 0;

  always @(negedge clk_i) begin : drive_cmds
    logic offer;
    offer = cmd_ch.valid && !cmd_taken;
    if (!rst_ni) begin
      offer               = 1'b0;
      cmd_ch.op           <= OP_NONE;
      cmd_ch.brick_left   <= '0;
      cmd_ch.brick_top    <= '0;
      cmd_ch.brick_width  <= '0;
      cmd_ch.brick_height <= '0;
      cmd_ch.query_left   <= '0;
      cmd_ch.query_right  <= '0;
    end else if (!offer) begin
      if (!have_cur && cmd_backlog.size() != 0) begin
        cur      = cmd_backlog.pop_front();
        have_cur = 1'b1;
        cur_wait = cur.gap;
      end
      if (have_cur) begin
        if (cur_wait != 0) begin
          cur_wait--;
        end else if (!cur.drain || status_due_q.size() == 0) begin
          offer               = 1'b1;
          have_cur            = 1'b0;
          cmd_ch.op           <= cur.op;
          cmd_ch.brick_left   <= cur.brick_left;
          cmd_ch.brick_top    <= cur.brick_top;
          cmd_ch.brick_width  <= cur.brick_width;
          cmd_ch.brick_height <= cur.brick_height;
          cmd_ch.query_left   <= cur.query_left;
          cmd_ch.query_right  <= cur.query_right;
        end
      end
    end
    cmd_ch.valid <= offer;
  end

  // ---------------------------------------------------------------------------
  // Receiver ready: a random stall before each result beat, plus the long
  // hold-off below that lets the block fill up and stall its input.
  // ---------------------------------------------------------------------------
  int unsigned rx_mode  = 1;
  int unsigned rx_stall = 0;

  always @(negedge clk_i) begin : drive_ready
    if (!rst_ni) begin
      status_ch.ready <= 1'b0;
    end else begin
      if (res_taken) begin
        if (results_seen % 40 == 0) rx_mode = $urandom_range(0, 2);
        rx_stall = draw_idle(rx_mode);
      end
      if (rx_stall != 0) begin
        rx_stall--;
        status_ch.ready <= 1'b0;
      end else begin
        status_ch.ready <= !sink_hold;
      end
    end
  end

  initial begin : long_hold_off
    wait (results_seen >= 500);
    @(posedge clk_i);
    sink_hold = 1'b1;
    repeat (400) @(posedge clk_i);
    sink_hold = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Monitor: at each rising edge an accepted command beat updates the predicted
  // map and queues its expected status; an accepted result beat is compared
  // with the oldest expected status.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : check_beats
    map_cmd_t    c;
    map_status_t want, got;
    cmd_taken = rst_ni && cmd_ch.valid && cmd_ch.ready;
    res_taken = rst_ni && status_ch.valid && status_ch.ready;

    if (cmd_taken) begin
      c = mk_cmd(op_e'(cmd_ch.op), cmd_ch.brick_left, cmd_ch.brick_top,
                 cmd_ch.brick_width, cmd_ch.brick_height,
                 cmd_ch.query_left, cmd_ch.query_right);
      want = apply_to_height_map(c);
      case (c.op)
        OP_ADD:   n_adds++;
        OP_QUERY: begin
          n_queries++;
          if (want.peak_height != '0) n_hits++;
        end
        OP_CLEAR: n_clears++;
        default:  n_unused++;
      endcase
      cmds_taken++;
      status_due_q.push_back(want);
    end

    if (res_taken) begin
      results_seen++;
      got.peak_height = status_ch.peak_height;
      got.world_empty = status_ch.world_empty;
      got.extent_x    = status_ch.extent_x_out;
      got.extent_y    = status_ch.extent_y_out;
      if (status_due_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("[%0t] result beat with nothing outstanding: h=%0h empty=%0b w=%0h ht=%0h",
                   $time, got.peak_height, got.world_empty, got.extent_x, got.extent_y);
      end else begin
        want = status_due_q.pop_front();
        if (got.peak_height !== want.peak_height || got.world_empty !== want.world_empty ||
            got.extent_x !== want.extent_x || got.extent_y !== want.extent_y)
        begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("[%0t] beat %0d differs: expected h=%0h empty=%0b w=%0h ht=%0h, %s",
                     $time, results_seen, want.peak_height, want.world_empty,
                     want.extent_x, want.extent_y,
                     $sformatf("got h=%0h empty=%0b w=%0h ht=%0h", got.peak_height,
                               got.world_empty, got.extent_x, got.extent_y));
        end
      end
    end
  end

  // End of run: every command taken, every result back, then a quiet stretch
  // so that a stray extra result beat would still be caught.
  initial begin : finish_run
    wait (total_cmds != 0);
    while (cmds_taken != total_cmds || status_due_q.size() != 0) @(posedge clk_i);
    repeat (64) @(posedge clk_i);
    $display("Run covered %0d adds, %0d queries (%0d with a nonzero height), %0d clears, %0d unused.",
             n_adds, n_queries, n_hits, n_clears, n_unused);
    $display("Result beats compared: %0d, differing: %0d.", results_seen, mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog: well beyond the slowest run this stimulus can produce.
  initial begin : watchdog
    #(100_000_000);
    $display("Mismatches found");
    $finish;
  end

endmodule

### column_height_map_range_max_core.f
design/chmr_pkg.sv
design/chmr_in_if.sv
design/chmr_out_if.sv
design/column_height_map_range_max.sv
verif/tb_column_height_map_range_max_core.sv
